// ===== rtl/assert_macros.svh =====
// Assertion macros used by hill27_ctrl.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every rising edge outside reset.
`define ASSERT_CLK(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// Condition that must never hold at a rising edge outside reset.
`define ASSERT_NEVER(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition seen");

`endif

// ===== rtl/hill27_pkg.sv =====
package hill27_pkg;

    localparam int unsigned SYM_W  = 5;
    localparam int unsigned CHAR_W = 8;
    localparam int unsigned PROD_W = 10;
    localparam int unsigned IDX_W  = 3;

    localparam logic [SYM_W-1:0]  SPACE_SYM   = 5'd26;
    localparam logic [SYM_W-1:0]  ALPHA_SYM   = 5'd27;
    localparam logic [CHAR_W-1:0] ASCII_A     = 8'd65;
    localparam logic [CHAR_W-1:0] ASCII_Z     = 8'd90;
    localparam logic [CHAR_W-1:0] ASCII_SPACE = 8'd32;

    localparam logic [IDX_W-1:0] CFG_KEY_TL   = 3'd0;
    localparam logic [IDX_W-1:0] CFG_KEY_TR   = 3'd1;
    localparam logic [IDX_W-1:0] CFG_KEY_BL   = 3'd2;
    localparam logic [IDX_W-1:0] CFG_KEY_BR   = 3'd3;
    localparam logic [IDX_W-1:0] CFG_DECRYPT  = 3'd4;

    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_DET_ZERO  = 2'd1,
        STATUS_DET_MULT3 = 2'd2,
        STATUS_BAD_BYTE  = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_AD,
        OP_BC,
        OP_M00,
        OP_M01,
        OP_M10,
        OP_M11,
        OP_T00,
        OP_T10,
        OP_T01,
        OP_T11
    } mul_op_t;

    typedef enum logic [1:0] {
        SEL_ERR,
        SEL_FIRST,
        SEL_SECOND
    } out_sel_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_D_AD,
        S_D_BC,
        S_D_WAIT,
        S_D_DET,
        S_D_M00,
        S_D_M01,
        S_D_M10,
        S_D_M11,
        S_D_DRAIN,
        S_DECIDE,
        S_T00,
        S_T10,
        S_T01,
        S_T11,
        S_SUM,
        S_OUT0,
        S_OUT1
    } ctrl_state_t;

    typedef struct packed {
        mul_op_t  op;
        logic     item_load;
        logic     hold;
        logic     clear_hold;
        logic     pair_load;
        logic     det_load;
        logic     out_load;
        out_sel_t out_sel;
    } cmd_t;

    typedef struct packed {
        status_t key_status;
        logic    item_bad;
        logic    item_last;
        logic    holding;
    } stat_t;

    // Remainder by 27 of a 10-bit value through a reciprocal multiply.
    function automatic logic [SYM_W-1:0] mod27_w10(input logic [PROD_W-1:0] x);
        logic [21:0]       recip;
        logic [5:0]        quot;
        logic [PROD_W-1:0] rem;
        recip = 22'(x) * 22'd2428;
        quot  = recip[21:16];
        rem   = x - (PROD_W'(quot) * PROD_W'(ALPHA_SYM));
        if (rem >= PROD_W'(ALPHA_SYM))
        begin
            rem = rem - PROD_W'(ALPHA_SYM);
        end
        return rem[SYM_W-1:0];
    endfunction

    function automatic logic [SYM_W-1:0] mod27_w5(input logic [SYM_W-1:0] x);
        return (x >= ALPHA_SYM) ? (x - ALPHA_SYM) : x;
    endfunction

    function automatic logic [SYM_W-1:0] neg27(input logic [SYM_W-1:0] x);
        return (x == '0) ? '0 : (ALPHA_SYM - x);
    endfunction

    function automatic logic [SYM_W-1:0] sum27(input logic [SYM_W-1:0] x,
                                               input logic [SYM_W-1:0] y);
        logic [SYM_W:0] s;
        s = {1'b0, x} + {1'b0, y};
        if (s >= {1'b0, ALPHA_SYM})
        begin
            s = s - {1'b0, ALPHA_SYM};
        end
        return s[SYM_W-1:0];
    endfunction

    // Multiplicative inverse mod 27; zero when none exists.
    function automatic logic [SYM_W-1:0] inv27(input logic [SYM_W-1:0] x);
        logic [SYM_W-1:0] r;
        unique case (x)
            5'd1:    r = 5'd1;
            5'd2:    r = 5'd14;
            5'd4:    r = 5'd7;
            5'd5:    r = 5'd11;
            5'd7:    r = 5'd4;
            5'd8:    r = 5'd17;
            5'd10:   r = 5'd19;
            5'd11:   r = 5'd5;
            5'd13:   r = 5'd25;
            5'd14:   r = 5'd2;
            5'd16:   r = 5'd22;
            5'd17:   r = 5'd8;
            5'd19:   r = 5'd10;
            5'd20:   r = 5'd23;
            5'd22:   r = 5'd16;
            5'd23:   r = 5'd20;
            5'd25:   r = 5'd13;
            5'd26:   r = 5'd26;
            default: r = 5'd0;
        endcase
        return r;
    endfunction

    function automatic logic [CHAR_W-1:0] sym_to_char(input logic [SYM_W-1:0] s);
        return (s < SPACE_SYM) ? (ASCII_A + CHAR_W'(s)) : ASCII_SPACE;
    endfunction

endpackage

// ===== rtl/hill_cipher_2x2_mod27.sv =====
// A byte that completes a pair passes the states DECIDE, T00, T10, T01, T11 and SUM
// before its first result is valid; its second result is valid in the cycle after the
// first is taken. A new byte is taken only in idle, not while a result is pending;
// the single shared multiply and mod-27 unit does every product. Reset is asynchronous,
// active low: identity key, encrypt mode, no symbol held, and the derived matrix is
// rebuilt before the first byte is taken.
module hill_cipher_2x2_mod27 (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  in_char,
    input  logic        in_last,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  out_char,
    output logic [1:0]  out_status,
    output logic        out_last,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [4:0]  cfg_data
);
    import hill27_pkg::*;

    cmd_t  cmd;
    stat_t stat;
    logic  cfg_we;

    assign cfg_we = cfg_valid && cfg_ready;

    hill27_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    hill27_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_char    (in_char),
        .in_last    (in_last),
        .cmd        (cmd),
        .stat       (stat),
        .out_char   (out_char),
        .out_status (out_status),
        .out_last   (out_last)
    );

endmodule

// ===== rtl/hill27_dp.sv =====
module hill27_dp (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [hill27_pkg::IDX_W-1:0]      cfg_index,
    input  logic [hill27_pkg::SYM_W-1:0]      cfg_data,
    input  logic [hill27_pkg::CHAR_W-1:0]     in_char,
    input  logic                              in_last,
    input  hill27_pkg::cmd_t                  cmd,
    output hill27_pkg::stat_t                 stat,
    output logic [hill27_pkg::CHAR_W-1:0]     out_char,
    output logic [1:0]                        out_status,
    output logic                              out_last
);
    import hill27_pkg::*;

    logic [SYM_W-1:0]  key_a_reg, key_b_reg, key_c_reg, key_d_reg;
    logic              decrypt_reg;
    logic [PROD_W-1:0] ad_raw_reg, bc_raw_reg;
    logic [SYM_W-1:0]  ad_mod_reg, bc_mod_reg;
    logic [SYM_W-1:0]  inv_reg;
    status_t           key_status_reg;
    logic [SYM_W-1:0]  m00_reg, m01_reg, m10_reg, m11_reg;
    logic [PROD_W-1:0] prod_reg;
    mul_op_t           prod_op_reg;
    logic [SYM_W-1:0]  item_sym_reg;
    logic              item_bad_reg;
    logic              item_last_reg;
    logic [SYM_W-1:0]  held_sym_reg;
    logic              holding_reg;
    logic [SYM_W-1:0]  p0_reg, p1_reg;
    logic [SYM_W-1:0]  t00_reg, t10_reg, t01_reg, t11_reg;
    logic [CHAR_W-1:0] out_char_reg;
    status_t           out_status_reg;
    logic              out_last_reg;

    logic [SYM_W-1:0]  a27, b27, c27, d27;
    logic [SYM_W-1:0]  opa, opb;
    logic [SYM_W-1:0]  mod_res;
    logic [SYM_W-1:0]  det_mod;
    logic [SYM_W-1:0]  inv_next;
    status_t           key_status_next;
    logic [SYM_W-1:0]  item_sym_next;
    logic              item_bad_next;

    assign a27 = mod27_w5(key_a_reg);
    assign b27 = mod27_w5(key_b_reg);
    assign c27 = mod27_w5(key_c_reg);
    assign d27 = mod27_w5(key_d_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_a_reg   <= 5'd1;
            key_b_reg   <= 5'd0;
            key_c_reg   <= 5'd0;
            key_d_reg   <= 5'd1;
            decrypt_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_KEY_TL:  key_a_reg   <= cfg_data;
                CFG_KEY_TR:  key_b_reg   <= cfg_data;
                CFG_KEY_BL:  key_c_reg   <= cfg_data;
                CFG_KEY_BR:  key_d_reg   <= cfg_data;
                CFG_DECRYPT: decrypt_reg <= cfg_data[0];
                default:     ;
            endcase
        end
    end

    always_comb
    begin
        opa = '0;
        opb = '0;
        unique case (cmd.op)
            OP_AD:
            begin
                opa = key_a_reg;
                opb = key_d_reg;
            end
            OP_BC:
            begin
                opa = key_b_reg;
                opb = key_c_reg;
            end
            OP_M00:
            begin
                opa = decrypt_reg ? d27 : a27;
                opb = decrypt_reg ? inv_reg : 5'd1;
            end
            OP_M01:
            begin
                opa = decrypt_reg ? neg27(b27) : b27;
                opb = decrypt_reg ? inv_reg : 5'd1;
            end
            OP_M10:
            begin
                opa = decrypt_reg ? neg27(c27) : c27;
                opb = decrypt_reg ? inv_reg : 5'd1;
            end
            OP_M11:
            begin
                opa = decrypt_reg ? a27 : d27;
                opb = decrypt_reg ? inv_reg : 5'd1;
            end
            OP_T00:
            begin
                opa = p0_reg;
                opb = m00_reg;
            end
            OP_T10:
            begin
                opa = p1_reg;
                opb = m10_reg;
            end
            OP_T01:
            begin
                opa = p0_reg;
                opb = m01_reg;
            end
            OP_T11:
            begin
                opa = p1_reg;
                opb = m11_reg;
            end
            default:
            begin
                opa = '0;
                opb = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_op_reg <= OP_NONE;
        end
        else
        begin
            prod_op_reg <= cmd.op;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= PROD_W'(opa) * PROD_W'(opb);
    end

    assign mod_res = mod27_w10(prod_reg);

    always_ff @(posedge clk)
    begin
        unique case (prod_op_reg)
            OP_AD:
            begin
                ad_raw_reg <= prod_reg;
                ad_mod_reg <= mod_res;
            end
            OP_BC:
            begin
                bc_raw_reg <= prod_reg;
                bc_mod_reg <= mod_res;
            end
            OP_M00:  m00_reg <= mod_res;
            OP_M01:  m01_reg <= mod_res;
            OP_M10:  m10_reg <= mod_res;
            OP_M11:  m11_reg <= mod_res;
            OP_T00:  t00_reg <= mod_res;
            OP_T10:  t10_reg <= mod_res;
            OP_T01:  t01_reg <= mod_res;
            OP_T11:  t11_reg <= mod_res;
            default: ;
        endcase
    end

    always_comb
    begin
        if (ad_mod_reg >= bc_mod_reg)
        begin
            det_mod = ad_mod_reg - bc_mod_reg;
        end
        else
        begin
            det_mod = SYM_W'({1'b0, ad_mod_reg} + {1'b0, ALPHA_SYM} - {1'b0, bc_mod_reg});
        end
        inv_next = inv27(det_mod);
        if (ad_raw_reg == bc_raw_reg)
        begin
            key_status_next = STATUS_DET_ZERO;
        end
        else if (inv_next == '0)
        begin
            key_status_next = STATUS_DET_MULT3;
        end
        else
        begin
            key_status_next = STATUS_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_status_reg <= STATUS_OK;
        end
        else if (cmd.det_load)
        begin
            key_status_reg <= key_status_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.det_load)
        begin
            inv_reg <= inv_next;
        end
    end

    always_comb
    begin
        item_bad_next = 1'b0;
        item_sym_next = '0;
        if ((in_char >= ASCII_A) && (in_char <= ASCII_Z))
        begin
            item_sym_next = SYM_W'(in_char - ASCII_A);
        end
        else if (in_char == ASCII_SPACE)
        begin
            item_sym_next = SPACE_SYM;
        end
        else
        begin
            item_bad_next = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.item_load)
        begin
            item_sym_reg  <= item_sym_next;
            item_bad_reg  <= item_bad_next;
            item_last_reg <= in_last;
        end
        if (cmd.pair_load)
        begin
            p0_reg <= holding_reg ? held_sym_reg : item_sym_reg;
            p1_reg <= holding_reg ? item_sym_reg : SPACE_SYM;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            holding_reg  <= 1'b0;
            held_sym_reg <= '0;
        end
        else if (cmd.clear_hold)
        begin
            holding_reg  <= 1'b0;
            held_sym_reg <= '0;
        end
        else if (cmd.hold)
        begin
            holding_reg  <= 1'b1;
            held_sym_reg <= item_sym_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            unique case (cmd.out_sel)
                SEL_FIRST:
                begin
                    out_char_reg   <= sym_to_char(sum27(t00_reg, t10_reg));
                    out_status_reg <= STATUS_OK;
                    out_last_reg   <= 1'b0;
                end
                SEL_SECOND:
                begin
                    out_char_reg   <= sym_to_char(sum27(t01_reg, t11_reg));
                    out_status_reg <= STATUS_OK;
                    out_last_reg   <= item_last_reg;
                end
                default:
                begin
                    out_char_reg   <= '0;
                    out_status_reg <= (key_status_reg != STATUS_OK) ? key_status_reg
                                                                    : STATUS_BAD_BYTE;
                    out_last_reg   <= item_last_reg;
                end
            endcase
        end
    end

    assign stat.key_status = key_status_reg;
    assign stat.item_bad   = item_bad_reg;
    assign stat.item_last  = item_last_reg;
    assign stat.holding    = holding_reg;

    assign out_char   = out_char_reg;
    assign out_status = out_status_reg;
    assign out_last   = out_last_reg;

endmodule

// ===== rtl/hill27_ctrl.sv =====
`include "assert_macros.svh"

module hill27_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  hill27_pkg::stat_t stat,
    output hill27_pkg::cmd_t  cmd
);
    import hill27_pkg::*;

    ctrl_state_t state_reg, state_next;
    logic        pending_reg, pending_next;
    logic        key_err;

    assign key_err   = (stat.key_status != STATUS_OK);
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            pending_reg <= 1'b1;
        end
        else
        begin
            state_reg   <= state_next;
            pending_reg <= pending_next;
        end
    end

    // A key write marks the derived matrix stale; it is rebuilt from idle.
    always_comb
    begin
        pending_next = pending_reg;
        if (cfg_valid && cfg_ready)
        begin
            pending_next = 1'b1;
        end
        else if ((state_reg == S_IDLE) && pending_reg)
        begin
            pending_next = 1'b0;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (pending_reg)
                begin
                    state_next = S_D_AD;
                end
                else if (in_valid)
                begin
                    state_next = S_DECIDE;
                end
            end
            S_D_AD:    state_next = S_D_BC;
            S_D_BC:    state_next = S_D_WAIT;
            S_D_WAIT:  state_next = S_D_DET;
            S_D_DET:   state_next = S_D_M00;
            S_D_M00:   state_next = S_D_M01;
            S_D_M01:   state_next = S_D_M10;
            S_D_M10:   state_next = S_D_M11;
            S_D_M11:   state_next = S_D_DRAIN;
            S_D_DRAIN: state_next = S_IDLE;
            S_DECIDE:
            begin
                priority if (key_err || stat.item_bad)
                begin
                    state_next = S_OUT1;
                end
                else if (stat.holding || stat.item_last)
                begin
                    state_next = S_T00;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_T00:     state_next = S_T10;
            S_T10:     state_next = S_T01;
            S_T01:     state_next = S_T11;
            S_T11:     state_next = S_SUM;
            S_SUM:     state_next = S_OUT0;
            S_OUT0:
            begin
                if (out_ready)
                begin
                    state_next = S_OUT1;
                end
            end
            S_OUT1:
            begin
                if (out_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:   state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready  = (state_reg == S_IDLE) && !pending_reg;
        out_valid = (state_reg == S_OUT0) || (state_reg == S_OUT1);
        cmd       = '0;
        cmd.op    = OP_NONE;
        cmd.out_sel = SEL_ERR;
        unique case (state_reg)
            S_IDLE:    cmd.item_load = in_valid && !pending_reg;
            S_D_AD:    cmd.op = OP_AD;
            S_D_BC:    cmd.op = OP_BC;
            S_D_DET:   cmd.det_load = 1'b1;
            S_D_M00:   cmd.op = OP_M00;
            S_D_M01:   cmd.op = OP_M01;
            S_D_M10:   cmd.op = OP_M10;
            S_D_M11:   cmd.op = OP_M11;
            S_DECIDE:
            begin
                priority if (key_err)
                begin
                    cmd.out_load   = 1'b1;
                    cmd.out_sel    = SEL_ERR;
                    cmd.clear_hold = 1'b1;
                end
                else if (stat.item_bad)
                begin
                    cmd.out_load   = 1'b1;
                    cmd.out_sel    = SEL_ERR;
                    cmd.clear_hold = stat.item_last;
                end
                else if (stat.holding || stat.item_last)
                begin
                    cmd.pair_load  = 1'b1;
                    cmd.clear_hold = 1'b1;
                end
                else
                begin
                    cmd.hold = 1'b1;
                end
            end
            S_T00:     cmd.op = OP_T00;
            S_T10:     cmd.op = OP_T10;
            S_T01:     cmd.op = OP_T01;
            S_T11:     cmd.op = OP_T11;
            S_SUM:
            begin
                cmd.out_load = 1'b1;
                cmd.out_sel  = SEL_FIRST;
            end
            S_OUT0:
            begin
                cmd.out_load = out_ready;
                cmd.out_sel  = SEL_SECOND;
            end
            default:   ;
        endcase
    end

    `ASSERT_NEVER(a_no_overlap, out_valid && in_ready)
    `ASSERT_NEVER(a_hold_when_empty, cmd.hold && stat.holding)
    `ASSERT_CLK(a_second_follows, (state_reg == S_OUT0) && out_ready |=> state_reg == S_OUT1)

endmodule
